>>> rtl/dnv_pkg.sv
// Shared widths, constants, register indexes and stage payload types for depth_noise_variance.
package dnv_pkg;

    // Coordinate width, signed Q8.16 at the default
    localparam int COORD_WIDTH = 24;

    // Squared range is exact: three squares of magnitudes at most 2^(W-1)
    localparam int R2_W   = 2 * COORD_WIDTH;
    localparam int HALF_W = COORD_WIDTH;
    localparam int ROOT_W = COORD_WIDTH;
    localparam int TRY_W  = R2_W + 1;

    // Coefficients, signed Q8.24
    localparam int COEF_W = 32;

    // Partial product width: signed coefficient times zero-extended operand half
    localparam int PP_W = COEF_W + HALF_W + 1;

    // Sigma before flooring, 56 fractional bits, with headroom for the three terms
    localparam int SIG_W       = 2 * COORD_WIDTH + 35;
    localparam int LIN_SHIFT   = 16;
    localparam int CONST_SHIFT = 32;
    localparam int SIG_SHIFT   = 40;
    localparam int FL_W        = SIG_W - SIG_SHIFT;
    localparam int MAG_W       = FL_W + 1;

    // Sigma magnitude, Q.16, and the output variance
    localparam int WIDE_W = 64;
    localparam int SQ_W   = 32;
    localparam int VAR_W  = 63;
    localparam logic [WIDE_W-1:0] SIGMA_MAG_MAX = 64'd3037000499;
    localparam logic [VAR_W-1:0]  VAR_MAX       = '1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_QUAD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONST = 2'd2;

    // Squared range out of the front end
    typedef struct packed {
        logic [R2_W-1:0] r2;
        logic            last;
    } t_sq;

    // Squared range and floor root out of the root pipeline
    typedef struct packed {
        logic [R2_W-1:0]   r2;
        logic [ROOT_W-1:0] root;
        logic              last;
    } t_rt;

    // Noise model coefficients
    typedef struct packed {
        logic signed [COEF_W-1:0] quad;
        logic signed [COEF_W-1:0] lin;
        logic signed [COEF_W-1:0] cnst;
    } t_coef;

    // One result
    typedef struct packed {
        logic [VAR_W-1:0] variance;
        logic             saturated;
        logic             last;
    } t_res;

endpackage

>>> rtl/dnv_if.sv
// Point, result and configuration channel interfaces for depth_noise_variance.
interface dnv_pt_if;
    import dnv_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          last_point;

    modport source (output valid, point_x, point_y, point_z, last_point, input ready);
    modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface dnv_res_if;
    import dnv_pkg::*;
    logic             valid;
    logic             ready;
    logic [VAR_W-1:0] variance;
    logic             saturated;
    logic             last_result;

    modport source (output valid, variance, saturated, last_result, input ready);
    modport sink   (input valid, variance, saturated, last_result, output ready);
endinterface

interface dnv_cfg_if;
    import dnv_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COEF_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/dnv_square.sv
// Front end: coordinate magnitudes, squares and exact squared range, three stages.
module dnv_square (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [dnv_pkg::COORD_WIDTH-1:0] i_x,
    input  logic signed [dnv_pkg::COORD_WIDTH-1:0] i_y,
    input  logic signed [dnv_pkg::COORD_WIDTH-1:0] i_z,
    input  logic                                  i_last,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output dnv_pkg::t_sq                          o_data
);
    import dnv_pkg::*;

    localparam int NSTG = 3;

    logic [NSTG-1:0]        r_vld;
    logic [NSTG-1:0]        r_last;
    logic [NSTG-1:0]        en;
    logic [COORD_WIDTH-1:0] r_mag_x, r_mag_y, r_mag_z;
    logic [COORD_WIDTH-1:0] n_mag_x, n_mag_y, n_mag_z;
    logic [R2_W-1:0]        r_sq_x, r_sq_y, r_sq_z;
    logic [R2_W-1:0]        n_sq_x, n_sq_y, n_sq_z;
    logic [R2_W-1:0]        r_r2;
    logic [R2_W-1:0]        n_r2;

    // Stage enables: a stage loads when empty or when the next one moves
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NSTG-1];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // Magnitudes; the most negative code maps to 2^(W-1), which still fits unsigned
    always_comb begin
        n_mag_x = i_x[COORD_WIDTH-1] ? (~$unsigned(i_x) + 1'b1) : $unsigned(i_x);
        n_mag_y = i_y[COORD_WIDTH-1] ? (~$unsigned(i_y) + 1'b1) : $unsigned(i_y);
        n_mag_z = i_z[COORD_WIDTH-1] ? (~$unsigned(i_z) + 1'b1) : $unsigned(i_z);
    end

    // Squares
    always_comb begin
        n_sq_x = R2_W'(r_mag_x) * R2_W'(r_mag_x);
        n_sq_y = R2_W'(r_mag_y) * R2_W'(r_mag_y);
        n_sq_z = R2_W'(r_mag_z) * R2_W'(r_mag_z);
    end

    // Sum stays below 2^R2_W since each square is at most 2^(R2_W-2)
    assign n_r2 = r_sq_x + r_sq_y + r_sq_z;

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_mag_x   <= n_mag_x;
            r_mag_y   <= n_mag_y;
            r_mag_z   <= n_mag_z;
            r_last[0] <= i_last;
        end
        if (en[1]) begin
            r_sq_x    <= n_sq_x;
            r_sq_y    <= n_sq_y;
            r_sq_z    <= n_sq_z;
            r_last[1] <= r_last[0];
        end
        if (en[2]) begin
            r_r2      <= n_r2;
            r_last[2] <= r_last[1];
        end
    end

    assign o_data.r2   = r_r2;
    assign o_data.last = r_last[NSTG-1];

endmodule

>>> rtl/dnv_sqrt.sv
// Floor square root of the squared range, one root bit per pipeline stage.
module dnv_sqrt (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  dnv_pkg::t_sq i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output dnv_pkg::t_rt o_data
);
    import dnv_pkg::*;

    localparam int NSTG = ROOT_W;
    localparam int AW   = R2_W + 2;

    logic [NSTG-1:0]   r_vld;
    logic [NSTG-1:0]   r_last;
    logic [NSTG-1:0]   en;
    logic [R2_W-1:0]   r_rem  [NSTG];
    logic [ROOT_W-1:0] r_root [NSTG];
    logic [R2_W-1:0]   r_r2   [NSTG];
    logic [R2_W-1:0]   s_rem  [NSTG];
    logic [ROOT_W-1:0] s_root [NSTG];
    logic [R2_W-1:0]   s_r2   [NSTG];
    logic [NSTG-1:0]   s_last;
    logic [R2_W-1:0]   n_rem  [NSTG];
    logic [ROOT_W-1:0] n_root [NSTG];

    // Stage enables
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // Stage inputs: the first stage starts with remainder = r2, root = 0
    always_comb begin
        s_rem[0]  = i_data.r2;
        s_root[0] = '0;
        s_r2[0]   = i_data.r2;
        s_last[0] = i_data.last;
        for (int k = 1; k < NSTG; k++) begin
            s_rem[k]  = r_rem[k-1];
            s_root[k] = r_root[k-1];
            s_r2[k]   = r_r2[k-1];
            s_last[k] = r_last[k-1];
        end
    end

    // Stage k decides root bit b: keep it if (root + 2^b)^2 still fits under r2
    always_comb begin
        logic [TRY_W-1:0] trial;
        int               b;
        for (int k = 0; k < NSTG; k++) begin
            b     = NSTG - 1 - k;
            trial = (TRY_W'(s_root[k]) << (b + 1)) + (TRY_W'(1) << (2 * b));
            if (TRY_W'(s_rem[k]) >= trial) begin
                n_rem[k]  = R2_W'(TRY_W'(s_rem[k]) - trial);
                n_root[k] = s_root[k] | (ROOT_W'(1) << b);
            end else begin
                n_rem[k]  = s_rem[k];
                n_root[k] = s_root[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (en[k]) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_r2[k]   <= s_r2[k];
                r_last[k] <= s_last[k];
            end
        end
    end

    assign o_data.r2   = r_r2[NSTG-1];
    assign o_data.root = r_root[NSTG-1];
    assign o_data.last = r_last[NSTG-1];

    // Root leaving the pipeline is the floor square root
    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (AW'(o_data.root) * AW'(o_data.root) <= AW'(o_data.r2)) &&
                    ((AW'(o_data.root) + 1'b1) * (AW'(o_data.root) + 1'b1) > AW'(o_data.r2)))
        else $error("root is not the floor square root of r2");

    // Upstream is only held off when every stage is full and the output stalls
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_vld) && !i_ready)
        else $error("root pipeline refused a transfer with a free stage");

endmodule

>>> rtl/dnv_sigma.sv
// Noise model back end: sigma from coefficients, floor, saturation and variance square.
module dnv_sigma (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dnv_pkg::t_coef i_coef,
    input  logic           i_valid,
    output logic           o_ready,
    input  dnv_pkg::t_rt   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output dnv_pkg::t_res  o_data
);
    import dnv_pkg::*;

    localparam int NSTG = 6;

    logic [NSTG-1:0]          r_vld;
    logic [NSTG-1:0]          r_last;
    logic [NSTG-1:0]          en;
    logic signed [PP_W-1:0]   r_pq_lo, r_pq_hi, r_pl;
    logic signed [PP_W-1:0]   n_pq_lo, n_pq_hi, n_pl;
    logic signed [COEF_W-1:0] r_cnst;
    logic signed [SIG_W-1:0]  r_qsum, r_lsum, r_sum;
    logic signed [SIG_W-1:0]  n_qsum, n_lsum, n_sum;
    logic signed [MAG_W-1:0]  fl_ext;
    logic [MAG_W-1:0]         r_mag;
    logic [MAG_W-1:0]         n_mag;
    logic [WIDE_W-1:0]        mag_wide;
    logic                     r_sat, n_sat;
    logic [SQ_W-1:0]          r_sq;
    logic [WIDE_W-1:0]        prod;
    logic [VAR_W-1:0]         r_var;
    logic                     r_sat_out;

    // Stage enables
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // Partial products: r2 split in two halves, root term on its own
    always_comb begin
        n_pq_lo = i_coef.quad * $signed({1'b0, i_data.r2[HALF_W-1:0]});
        n_pq_hi = i_coef.quad * $signed({1'b0, i_data.r2[R2_W-1:HALF_W]});
        n_pl    = i_coef.lin  * $signed({1'b0, i_data.root});
    end

    // Quadratic term, and linear plus constant term, aligned to 56 fractional bits
    always_comb begin
        n_qsum = (SIG_W'(r_pq_hi) <<< HALF_W) + SIG_W'(r_pq_lo);
        n_lsum = (SIG_W'(r_pl) <<< LIN_SHIFT) + (SIG_W'(r_cnst) <<< CONST_SHIFT);
    end

    assign n_sum = r_qsum + r_lsum;

    // Floor to 16 fractional bits by dropping low bits, then take the magnitude
    always_comb begin
        fl_ext = MAG_W'($signed(r_sum[SIG_W-1:SIG_SHIFT]));
        n_mag  = fl_ext[MAG_W-1] ? $unsigned(-fl_ext) : $unsigned(fl_ext);
    end

    // Saturation check against the largest magnitude whose square fits
    always_comb begin
        mag_wide = WIDE_W'(r_mag);
        n_sat    = mag_wide > SIGMA_MAG_MAX;
    end

    assign prod = WIDE_W'(r_sq) * WIDE_W'(r_sq);

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_pq_lo   <= n_pq_lo;
            r_pq_hi   <= n_pq_hi;
            r_pl      <= n_pl;
            r_cnst    <= i_coef.cnst;
            r_last[0] <= i_data.last;
        end
        if (en[1]) begin
            r_qsum    <= n_qsum;
            r_lsum    <= n_lsum;
            r_last[1] <= r_last[0];
        end
        if (en[2]) begin
            r_sum     <= n_sum;
            r_last[2] <= r_last[1];
        end
        if (en[3]) begin
            r_mag     <= n_mag;
            r_last[3] <= r_last[2];
        end
        if (en[4]) begin
            r_sat     <= n_sat;
            r_sq      <= mag_wide[SQ_W-1:0];
            r_last[4] <= r_last[3];
        end
        if (en[5]) begin
            r_var     <= r_sat ? VAR_MAX : prod[VAR_W-1:0];
            r_sat_out <= r_sat;
            r_last[5] <= r_last[4];
        end
    end

    assign o_data.variance  = r_var;
    assign o_data.saturated = r_sat_out;
    assign o_data.last      = r_last[NSTG-1];

    // Clipped results carry the full-scale variance
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.saturated |-> o_data.variance == VAR_MAX)
        else $error("saturated result without full-scale variance");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Upstream is only held off when every stage is full and the output stalls
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_vld) && !i_ready)
        else $error("sigma pipeline refused a transfer with a free stage");

endmodule

>>> rtl/depth_noise_variance.sv
// Top level of depth_noise_variance: coefficient registers and the three pipeline sections.
// Per-point depth noise variance. Each point transfer (signed Q8.16 x, y, z) yields one
// result: the exact squared range, its floor square root, sigma = c1*r^2 + c2*r + c3 with
// Q8.24 coefficients floored to 16 fractional bits, and sigma^2 as unsigned Q31.32,
// clipped to full scale with the saturated flag set. The block takes one point every
// cycle while the result side keeps up; each result passes 3 front-end stages, one
// stage per root bit for the 24-bit square root and 6 back-end stages. A full stage only
// stalls when the stage ahead cannot load, so empty slots fill up while the output waits.
// Write the coefficients only while no point is in flight; they reset to zero.
module depth_noise_variance (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dnv_pt_if.sink    i_pt,
    dnv_res_if.source o_res,
    dnv_cfg_if.sink   i_cfg
);
    import dnv_pkg::*;

    t_coef r_coef;
    logic  sq_ready, sq_valid, rt_ready, rt_valid, sg_ready;
    t_sq   sq_data;
    t_rt   rt_data;
    t_res  res_data;

    // Coefficient registers; writes beyond the last index are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_QUAD:  r_coef.quad <= $signed(i_cfg.data);
                REG_LIN:   r_coef.lin  <= $signed(i_cfg.data);
                REG_CONST: r_coef.cnst <= $signed(i_cfg.data);
                default: begin
                end
            endcase
        end
    end

    // Squared range
    dnv_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pt.valid),
        .o_ready (sq_ready),
        .i_x     (i_pt.point_x),
        .i_y     (i_pt.point_y),
        .i_z     (i_pt.point_z),
        .i_last  (i_pt.last_point),
        .o_valid (sq_valid),
        .i_ready (rt_ready),
        .o_data  (sq_data)
    );

    assign i_pt.ready = sq_ready;

    // Range
    dnv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .o_ready (rt_ready),
        .i_data  (sq_data),
        .o_valid (rt_valid),
        .i_ready (sg_ready),
        .o_data  (rt_data)
    );

    // Sigma and variance
    dnv_sigma u_sigma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (r_coef),
        .i_valid (rt_valid),
        .o_ready (sg_ready),
        .i_data  (rt_data),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (res_data)
    );

    assign o_res.variance    = res_data.variance;
    assign o_res.saturated   = res_data.saturated;
    assign o_res.last_result = res_data.last;

endmodule

>>> tb/depth_noise_variance_tb.sv
// Self-checking testbench for depth_noise_variance against a bit-exact variance predictor.
module depth_noise_variance_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dnv_pkg::*;

    // Unused register index: writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    localparam int QUIET_LIMIT = 4000;  // cycles without any transfer before giving up
    localparam int TAIL_CYCLES = 60;    // pipeline is 33 deep, watch a while for strays
    localparam int MAX_REPORTS = 100;

    // Predicts one variance result per accepted point and checks results in order
    class variance_scoreboard;
        logic signed [COEF_W-1:0] quad_c;
        logic signed [COEF_W-1:0] lin_c;
        logic signed [COEF_W-1:0] const_c;
        t_res owed[$];
        int   errors, reports, points, results, clipped, negative;

        function new();
            quad_c  = '0;
            lin_c   = '0;
            const_c = '0;
        endfunction

        function void coeff_written(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
            case (idx)
                REG_QUAD:  quad_c  = data;
                REG_LIN:   lin_c   = data;
                REG_CONST: const_c = data;
                default: ;
            endcase
        endfunction

        function void point_taken(logic signed [COORD_WIDTH-1:0] px, py, pz, logic last);
            longint              sx, sy, sz;
            logic [63:0]         r2, root, trial;
            logic signed [127:0] cq, cl, cc, wr2, wroot, sigma;
            logic [127:0]        mag;
            t_res                want;
            points++;
            sx = longint'(px);
            sy = longint'(py);
            sz = longint'(pz);
            if (sx < 0) sx = -sx;
            if (sy < 0) sy = -sy;
            if (sz < 0) sz = -sz;
            r2 = sx * sx + sy * sy + sz * sz;

            // floor square root, one root bit at a time
            root = '0;
            for (int b = ROOT_W - 1; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= r2) root = trial;
            end

            // sigma with 56 fractional bits, then floor to 16
            cq    = 128'(quad_c);
            cl    = 128'(lin_c);
            cc    = 128'(const_c);
            wr2   = 128'(r2);
            wroot = 128'(root);
            sigma = cq * wr2 + cl * (wroot <<< LIN_SHIFT) + (cc <<< CONST_SHIFT);
            sigma = sigma >>> SIG_SHIFT;
            if (sigma < 0) begin
                negative++;
                mag = -sigma;
            end else begin
                mag = sigma;
            end

            want.last = last;
            if (mag > SIGMA_MAG_MAX) begin
                clipped++;
                want.variance  = VAR_MAX;
                want.saturated = 1'b1;
            end else begin
                want.variance  = VAR_W'(mag[63:0] * mag[63:0]);
                want.saturated = 1'b0;
            end
            owed = {owed, want};
        endfunction

        function void result_seen(logic [VAR_W-1:0] v, logic sat, logic last);
            t_res want;
            results++;
            if (owed.size() == 0) begin
                errors++;
                if (reports++ < MAX_REPORTS)
                    $display("%0t: result with nothing pending: expected none, actual %h/%b/%b",
                             $time, v, sat, last);
                return;
            end
            want = owed.pop_front();
            if (v !== want.variance) begin
                errors++;
                if (reports++ < MAX_REPORTS)
                    $display("%0t: variance expected %h actual %h", $time, want.variance, v);
            end
            if (sat !== want.saturated) begin
                errors++;
                if (reports++ < MAX_REPORTS)
                    $display("%0t: saturated expected %b actual %b", $time, want.saturated, sat);
            end
            if (last !== want.last) begin
                errors++;
                if (reports++ < MAX_REPORTS)
                    $display("%0t: last_result expected %b actual %b", $time, want.last, last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;          // final stretch: no idling on either side
    int   src_free;      // points left in a gap-free stretch
    int   stall_left;    // result-side stall cycles left
    int   free_left;     // result-side stall-free cycles left
    int   settings = 1;  // coefficient settings exercised, reset defaults included
    int   quiet_cycles = 0;

    variance_scoreboard board = new();

    dnv_pt_if  pt_bus();
    dnv_res_if res_bus();
    dnv_cfg_if cfg_bus();

    depth_noise_variance dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pt    (pt_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Monitors: every transfer goes to the scoreboard
    always @(posedge clk) begin
        if (rst_n && pt_bus.valid && pt_bus.ready)
            board.point_taken(pt_bus.point_x, pt_bus.point_y, pt_bus.point_z,
                              pt_bus.last_point);
        if (rst_n && res_bus.valid && res_bus.ready)
            board.result_seen(res_bus.variance, res_bus.saturated, res_bus.last_result);
        if (rst_n && cfg_bus.valid && cfg_bus.ready)
            board.coeff_written(cfg_bus.index, cfg_bus.data);
    end

    // Watchdog on cycles with no transfer anywhere
    always @(posedge clk) begin
        if ((pt_bus.valid && pt_bus.ready) || (res_bus.valid && res_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result-side ready: stall bursts mixed with stall-free stretches
    initial begin
        res_bus.ready = 1'b0;
        stall_left    = 0;
        free_left     = 0;
        forever begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (free_left > 0)
                free_left--;
            else if (!calm && $urandom_range(0, 19) == 0)
                free_left = $urandom_range(30, 120);
            else if (!calm && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 11);
            res_bus.ready <= rst_n && (stall_left == 0);
        end
    end

    // One coefficient write transfer, valid dropped for a cycle afterwards
    task automatic write_coeff(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending and let every pending result come out
    task automatic wait_idle();
        pt_bus.valid <= 1'b0;
        @(posedge clk);
        while (board.owed.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_coeffs(logic [COEF_W-1:0] q, l, c);
        wait_idle();
        write_coeff(REG_QUAD, q);
        write_coeff(REG_LIN, l);
        write_coeff(REG_CONST, c);
        settings++;
    endtask

    // One point transfer, sometimes preceded by a random source gap
    task automatic send_point(logic signed [COORD_WIDTH-1:0] px, py, pz, logic last);
        if (src_free > 0) begin
            src_free--;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
            src_free = $urandom_range(20, 80);
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            pt_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        pt_bus.valid      <= 1'b1;
        pt_bus.point_x    <= px;
        pt_bus.point_y    <= py;
        pt_bus.point_z    <= pz;
        pt_bus.last_point <= last;
        do @(posedge clk); while (!pt_bus.ready);
    endtask

    // Random point: full range, short ranges, edge values or one dominant axis
    task automatic send_random_point();
        logic signed [COORD_WIDTH-1:0] c [3];
        int shape, dom;
        shape = $urandom_range(0, 9);
        dom   = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
            c[k] = COORD_WIDTH'($urandom);
            if (shape >= 4 && shape <= 6) begin
                c[k] = c[k] >>> $urandom_range(0, 20);
            end else if (shape == 7) begin
                case ($urandom_range(0, 4))
                    0: c[k] = COORD_MIN;
                    1: c[k] = COORD_MAX;
                    2: c[k] = '0;
                    3: c[k] = COORD_WIDTH'(1);
                    default: c[k] = '1;
                endcase
            end else if (shape >= 8 && k != dom) begin
                c[k] = c[k] >>> 16;
            end
        end
        send_point(c[0], c[1], c[2], $urandom_range(0, 15) == 0);
    endtask

    // Coefficient with a random scale, sometimes full range
    function automatic logic [COEF_W-1:0] random_coeff();
        logic signed [COEF_W-1:0] raw;
        raw = $urandom;
        if ($urandom_range(0, 3) != 0) raw = raw >>> $urandom_range(4, 31);
        return raw;
    endfunction

    // Stimulus
    initial begin
        rst_n             = 1'b0;
        calm              = 1'b0;
        src_free          = 0;
        pt_bus.valid      = 1'b0;
        pt_bus.point_x    = '0;
        pt_bus.point_y    = '0;
        pt_bus.point_z    = '0;
        pt_bus.last_point = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = '0;
        cfg_bus.data      = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset coefficients are zero, so every variance is zero
        send_point('0, '0, '0, 1'b0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        send_point(COORD_MIN, COORD_MAX, '0, 1'b0);

        // Plausible sensor model, plus a write to the unused index
        load_coeffs(32'h0001_0000, 32'h0010_0000, 32'h0040_0000);
        write_coeff(REG_SPARE, $urandom);
        send_point('0, '0, '0, 1'b0);
        send_point(COORD_WIDTH'(1), '0, '0, 1'b0);
        send_point(COORD_WIDTH'(1), COORD_WIDTH'(1), COORD_WIDTH'(1), 1'b0);  // r2 != root^2
        send_point('1, '1, '1, 1'b0);
        send_point(COORD_MAX, '0, '0, 1'b0);
        send_point('0, COORD_MIN, '0, 1'b0);
        send_point('0, '0, COORD_MAX, 1'b1);
        send_point(24'sh010000, 24'sh010000, 24'sh010000, 1'b0);
        send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        send_point(24'sh030000, -24'sh040000, '0, 1'b1);  // range of exactly 5 m

        // Largest positive coefficients: clipping
        load_coeffs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point('0, '0, '0, 1'b0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);

        // Most negative coefficients: negative sigma, squared as usual
        load_coeffs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point('0, '0, '0, 1'b0);
        send_point(COORD_WIDTH'(1), '0, '0, 1'b0);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);

        // sigma = 1 - range: crosses zero at one meter
        load_coeffs('0, 32'hFF00_0000, 32'h0100_0000);
        send_point(24'sh008000, '0, '0, 1'b0);
        send_point(24'sh010000, '0, '0, 1'b0);
        send_point(24'sh020000, '0, '0, 1'b1);

        // Random coefficient settings, each with a random cloud
        for (int ph = 0; ph < 7; ph++) begin
            load_coeffs(random_coeff(), random_coeff(), random_coeff());
            repeat (170) send_random_point();
        end

        // Final stretch at full rate
        load_coeffs(32'h0000_4000, 32'h0020_0000, 32'h0080_0000);
        calm = 1'b1;
        repeat (200) send_random_point();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d points under %0d coefficient settings, checked %0d results.",
                 board.points, settings, board.results);
        $display("Clipped results: %0d, negative sigma: %0d, mismatches: %0d.",
                 board.clipped, board.negative, board.errors);
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (board.owed.size() != 0)
                $display("%0t: %0d expected results never arrived", $time, board.owed.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
